@@ hw/rtl/spsd_pkg.sv @@
// Shared types and constants of the SYN port scan detector.
`default_nettype none
package spsd_pkg;

  localparam int SOURCES_DEFAULT    = 8;
  localparam int EPOCH_BITS_DEFAULT = 16;
  localparam int PORT_BITS          = 16;
  localparam int COUNT_BITS         = 17;

  localparam logic [63:0] WINDOW_RESET    = 64'd30000000000;
  localparam logic [16:0] THRESHOLD_RESET = 17'd24;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [15:0] MIN_FRAME_LEN  = 16'd54;
  localparam logic [3:0]  MIN_IHL_WORDS  = 4'd5;
  localparam logic [15:0] ETH_TCP_BYTES  = 16'd34;

  typedef enum logic [7:0] {
    CFG_WINDOW_LENGTH = 8'd0,
    CFG_PORT_THRESHOLD = 8'd1
  } cfg_index_t;

  typedef struct packed {
    logic [15:0] frame_length;
    logic [15:0] ether_type;
    logic [3:0]  header_words;
    logic [7:0]  ip_protocol;
    logic        syn_flag;
    logic        ack_flag;
    logic [31:0] source_address;
    logic [15:0] dest_port;
    logic [63:0] now_ns;
  } frame_t;

  typedef struct packed {
    logic        drop;
    logic        alert_valid;
    logic        alert_reason;
    logic [31:0] alert_address;
    logic [15:0] alert_port;
    logic [16:0] distinct_ports;
    logic [63:0] alert_total;
  } verdict_t;

  typedef struct packed {
    logic   valid;
    logic   track;
    frame_t frame;
  } q_head_t;

endpackage
`default_nettype wire

@@ hw/rtl/spsd_front.sv @@
// Front part: classify incoming frames and queue them for the back part.
`default_nettype none
module spsd_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            frame_valid,
  output logic                 frame_stall,
  input  wire spsd_pkg::frame_t frame,
  input  wire logic            clearing,
  input  wire logic            pop,
  output spsd_pkg::q_head_t    head
);

  logic                 q_track [2];
  spsd_pkg::frame_t     q_frame [2];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           count;
  logic                 push;
  logic                 track;
  logic [15:0]          need_len;

  assign frame_stall = (count == 2'd2) || clearing;
  assign push        = frame_valid && !frame_stall;

  always_comb begin
    need_len = {10'd0, frame.header_words, 2'b00} + spsd_pkg::ETH_TCP_BYTES;
    track = (frame.frame_length >= spsd_pkg::MIN_FRAME_LEN) &&
            (frame.ether_type == spsd_pkg::ETHERTYPE_IPV4) &&
            (frame.header_words >= spsd_pkg::MIN_IHL_WORDS) &&
            (need_len <= frame.frame_length) &&
            (frame.ip_protocol == spsd_pkg::PROTO_TCP) &&
            frame.syn_flag && !frame.ack_flag;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_track[wr_ptr] <= track;
      q_frame[wr_ptr] <= frame;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign head.valid = (count != 2'd0);
  assign head.track = q_track[rd_ptr];
  assign head.frame = q_frame[rd_ptr];

endmodule
`default_nettype wire

@@ hw/rtl/spsd_back.sv @@
// Back part: source slots, port-seen memory, alert logic and result register.
`default_nettype none
module spsd_back #(
  parameter int SOURCES    = spsd_pkg::SOURCES_DEFAULT,
  parameter int EPOCH_BITS = spsd_pkg::EPOCH_BITS_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire spsd_pkg::q_head_t head,
  output logic                   pop,
  output logic                   clearing,
  input  wire logic [63:0]       window_length_ns,
  input  wire logic [16:0]       ports_limit,
  output logic                   verdict_valid,
  input  wire logic              verdict_stall,
  output spsd_pkg::verdict_t     verdict
);

  localparam int SLOT_W    = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int TAG_W     = EPOCH_BITS + 1;
  localparam int MEM_AW    = SLOT_W + spsd_pkg::PORT_BITS;
  localparam int MEM_DEPTH = SOURCES * (2 ** spsd_pkg::PORT_BITS);

  typedef enum logic [1:0] {S_IDLE, S_UPDATE, S_FINISH} state_t;

  state_t                  state;
  logic                    slot_valid        [SOURCES];
  logic [31:0]             slot_address      [SOURCES];
  logic [63:0]             slot_window_start [SOURCES];
  logic [EPOCH_BITS-1:0]   slot_epoch        [SOURCES];
  logic [16:0]             slot_port_count   [SOURCES];
  logic                    slot_blocked      [SOURCES];
  logic [SLOT_W-1:0]       slot_recency      [SOURCES];
  logic [TAG_W-1:0]        port_seen         [MEM_DEPTH];

  logic [MEM_AW-1:0]       clear_addr;
  logic [TAG_W-1:0]        rd_tag;
  logic [SLOT_W-1:0]       cur_slot;
  logic                    cur_alloc;
  spsd_pkg::frame_t        cur_frame;
  logic [EPOCH_BITS-1:0]   cur_epoch;
  logic [16:0]             cur_count;
  logic                    cur_blocked;
  logic [63:0]             alert_count;

  logic                    out_free;
  logic                    hit;
  logic                    free_found;
  logic [SLOT_W-1:0]       hit_idx;
  logic [SLOT_W-1:0]       free_idx;
  logic [SLOT_W-1:0]       lru_idx;
  logic [SLOT_W-1:0]       pick_idx;
  logic                    expired;
  logic [EPOCH_BITS-1:0]   epoch_next;
  logic [MEM_AW-1:0]       rd_addr;
  logic                    seen;
  logic [16:0]             count_next;
  logic                    fire_alert;
  logic                    fire_reason;
  logic                    finish;
  logic                    mem_we;
  logic [MEM_AW-1:0]       mem_waddr;
  logic [TAG_W-1:0]        mem_wdata;
  logic                    load_verdict;
  spsd_pkg::verdict_t      verdict_next;

  assign out_free = !verdict_valid || !verdict_stall;
  assign pop = (state == S_IDLE) && head.valid && !clearing && (head.track || out_free);

  always_comb begin
    hit        = 1'b0;
    free_found = 1'b0;
    hit_idx    = '0;
    free_idx   = '0;
    lru_idx    = '0;
    for (int i = 0; i < SOURCES; i++) begin
      if (slot_valid[i] && (slot_address[i] == head.frame.source_address) && !hit) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (!slot_valid[i] && !free_found) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
      if (slot_recency[i] == SLOT_W'(SOURCES - 1)) lru_idx = SLOT_W'(i);
    end
    pick_idx = hit ? hit_idx : (free_found ? free_idx : lru_idx);
  end

  always_comb begin
    expired    = (cur_frame.now_ns - slot_window_start[cur_slot]) > window_length_ns;
    epoch_next = slot_epoch[cur_slot] + EPOCH_BITS'(1);
    rd_addr    = {cur_slot, cur_frame.dest_port};
    seen       = (rd_tag == {1'b1, cur_epoch});
    count_next = cur_count + 17'd1;
    fire_alert  = !seen && (cur_blocked || (count_next >= ports_limit));
    fire_reason = cur_blocked;
    finish     = (state == S_FINISH) && out_free;
    mem_we     = clearing || (finish && !seen);
    mem_waddr  = clearing ? clear_addr : rd_addr;
    mem_wdata  = clearing ? '0 : {1'b1, cur_epoch};
    load_verdict = (pop && !head.track) || finish;
    verdict_next = '0;
    verdict_next.alert_total = alert_count;
    if (state == S_FINISH) begin
      if (seen) begin
        verdict_next.drop           = 1'b1;
        verdict_next.distinct_ports = cur_count;
      end else begin
        verdict_next.distinct_ports = count_next;
        if (fire_alert) begin
          verdict_next.drop          = 1'b1;
          verdict_next.alert_valid   = 1'b1;
          verdict_next.alert_reason  = fire_reason;
          verdict_next.alert_address = cur_frame.source_address;
          verdict_next.alert_port    = cur_frame.dest_port;
          verdict_next.alert_total   = alert_count + 64'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) port_seen[mem_waddr] <= mem_wdata;
    if (state == S_UPDATE) rd_tag <= port_seen[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      clearing      <= 1'b1;
      clear_addr    <= '0;
      alert_count   <= '0;
      verdict_valid <= 1'b0;
      for (int i = 0; i < SOURCES; i++) begin
        slot_valid[i]   <= 1'b0;
        slot_epoch[i]   <= '0;
        slot_recency[i] <= SLOT_W'(i);
      end
    end else begin
      if (load_verdict) begin
        verdict_valid <= 1'b1;
        verdict       <= verdict_next;
      end else if (!verdict_stall) begin
        verdict_valid <= 1'b0;
      end
      if (clearing) begin
        clear_addr <= clear_addr + MEM_AW'(1);
        if (clear_addr == MEM_AW'(MEM_DEPTH - 1)) clearing <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop && head.track) begin
            cur_frame <= head.frame;
            cur_slot  <= pick_idx;
            cur_alloc <= !hit;
            state     <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          for (int i = 0; i < SOURCES; i++) begin
            if (slot_recency[i] < slot_recency[cur_slot]) begin
              slot_recency[i] <= slot_recency[i] + SLOT_W'(1);
            end
          end
          slot_recency[cur_slot] <= '0;
          if (cur_alloc || expired) begin
            slot_valid[cur_slot]        <= 1'b1;
            slot_address[cur_slot]      <= cur_frame.source_address;
            slot_window_start[cur_slot] <= cur_frame.now_ns;
            slot_epoch[cur_slot]        <= epoch_next;
            slot_port_count[cur_slot]   <= '0;
            slot_blocked[cur_slot]      <= 1'b0;
            cur_epoch   <= epoch_next;
            cur_count   <= '0;
            cur_blocked <= 1'b0;
          end else begin
            cur_epoch   <= slot_epoch[cur_slot];
            cur_count   <= slot_port_count[cur_slot];
            cur_blocked <= slot_blocked[cur_slot];
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            if (!seen) begin
              slot_port_count[cur_slot] <= count_next;
              if (fire_alert) begin
                slot_blocked[cur_slot] <= 1'b1;
                alert_count            <= alert_count + 64'd1;
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_pop_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !pop)
    else $error("request taken during clearing pass");

  a_alert_counts: assert property (@(posedge clk) disable iff (rst)
    (finish && fire_alert && !seen) |=> (alert_count == $past(alert_count) + 64'd1))
    else $error("alert not counted");

  a_alert_drops: assert property (@(posedge clk) disable iff (rst)
    (verdict_valid && verdict.alert_valid) |-> verdict.drop)
    else $error("alert without drop");

endmodule
`default_nettype wire

@@ hw/rtl/syn_port_scan_detector.sv @@
// Top level of the SYN port scan detector: configuration registers and the two parts.
//
// One verdict per frame, in order. A tracked TCP SYN goes through slot search,
// slot update with port-seen memory read, and tag check and write, set by the
// read-modify-write of the single-port port-seen memory; other frames skip them.
// After reset the block clears that memory, one entry a cycle (SOURCES * 65536
// entries), and takes no frames until done; configuration writes are taken at any
// time. A two-entry queue sits between front and back.
`default_nettype none
module syn_port_scan_detector #(
  parameter int SOURCES    = spsd_pkg::SOURCES_DEFAULT,
  parameter int EPOCH_BITS = spsd_pkg::EPOCH_BITS_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               frame_valid,
  output logic                    frame_stall,
  input  wire spsd_pkg::frame_t   frame,
  output logic                    verdict_valid,
  input  wire logic               verdict_stall,
  output spsd_pkg::verdict_t      verdict,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [7:0]         cfg_index,
  input  wire logic [63:0]        cfg_data
);

  logic [63:0]       window_length_ns;
  logic [16:0]       ports_limit;
  logic              clearing;
  logic              pop;
  spsd_pkg::q_head_t head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length_ns <= spsd_pkg::WINDOW_RESET;
      ports_limit      <= spsd_pkg::THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        spsd_pkg::CFG_WINDOW_LENGTH:  window_length_ns <= cfg_data;
        spsd_pkg::CFG_PORT_THRESHOLD: ports_limit      <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  spsd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame       (frame),
    .clearing    (clearing),
    .pop         (pop),
    .head        (head)
  );

  spsd_back #(
    .SOURCES    (SOURCES),
    .EPOCH_BITS (EPOCH_BITS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .head             (head),
    .pop              (pop),
    .clearing         (clearing),
    .window_length_ns (window_length_ns),
    .ports_limit      (ports_limit),
    .verdict_valid    (verdict_valid),
    .verdict_stall    (verdict_stall),
    .verdict          (verdict)
  );

endmodule
`default_nettype wire
